/* rtl/md2_pkg.sv */
// ----------------------------------------------------------------------------
// md2_pkg
// Shared types, constants and the MD2 substitution table.
// ----------------------------------------------------------------------------
`default_nettype none
package md2_pkg;

  localparam int unsigned BlkLen  = 16;
  localparam int unsigned XLen    = 48;
  localparam int unsigned NRounds = 18;

  // Operation codes of the input beat.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Command from the controller to the state memory unit.
  typedef struct packed {
    logic       we;
    logic [5:0] waddr;
    logic [7:0] wdata;
    logic [5:0] raddr;
  } md2_mem_cmd_t;

  // MD2 substitution table, built from the digits of pi.
  function automatic logic [7:0] md2_sbox(input logic [7:0] idx);
    logic [7:0] s;
    case (idx)
      8'd0: s = 8'd41; 8'd1: s = 8'd46; 8'd2: s = 8'd67; 8'd3: s = 8'd201;
      8'd4: s = 8'd162; 8'd5: s = 8'd216; 8'd6: s = 8'd124; 8'd7: s = 8'd1;
      8'd8: s = 8'd61; 8'd9: s = 8'd54; 8'd10: s = 8'd84; 8'd11: s = 8'd161;
      8'd12: s = 8'd236; 8'd13: s = 8'd240; 8'd14: s = 8'd6; 8'd15: s = 8'd19;
      8'd16: s = 8'd98; 8'd17: s = 8'd167; 8'd18: s = 8'd5; 8'd19: s = 8'd243;
      8'd20: s = 8'd192; 8'd21: s = 8'd199; 8'd22: s = 8'd115; 8'd23: s = 8'd140;
      8'd24: s = 8'd152; 8'd25: s = 8'd147; 8'd26: s = 8'd43; 8'd27: s = 8'd217;
      8'd28: s = 8'd188; 8'd29: s = 8'd76; 8'd30: s = 8'd130; 8'd31: s = 8'd202;
      8'd32: s = 8'd30; 8'd33: s = 8'd155; 8'd34: s = 8'd87; 8'd35: s = 8'd60;
      8'd36: s = 8'd253; 8'd37: s = 8'd212; 8'd38: s = 8'd224; 8'd39: s = 8'd22;
      8'd40: s = 8'd103; 8'd41: s = 8'd66; 8'd42: s = 8'd111; 8'd43: s = 8'd24;
      8'd44: s = 8'd138; 8'd45: s = 8'd23; 8'd46: s = 8'd229; 8'd47: s = 8'd18;
      8'd48: s = 8'd190; 8'd49: s = 8'd78; 8'd50: s = 8'd196; 8'd51: s = 8'd214;
      8'd52: s = 8'd218; 8'd53: s = 8'd158; 8'd54: s = 8'd222; 8'd55: s = 8'd73;
      8'd56: s = 8'd160; 8'd57: s = 8'd251; 8'd58: s = 8'd245; 8'd59: s = 8'd142;
      8'd60: s = 8'd187; 8'd61: s = 8'd47; 8'd62: s = 8'd238; 8'd63: s = 8'd122;
      8'd64: s = 8'd169; 8'd65: s = 8'd104; 8'd66: s = 8'd121; 8'd67: s = 8'd145;
      8'd68: s = 8'd21; 8'd69: s = 8'd178; 8'd70: s = 8'd7; 8'd71: s = 8'd63;
      8'd72: s = 8'd148; 8'd73: s = 8'd194; 8'd74: s = 8'd16; 8'd75: s = 8'd137;
      8'd76: s = 8'd11; 8'd77: s = 8'd34; 8'd78: s = 8'd95; 8'd79: s = 8'd33;
      8'd80: s = 8'd128; 8'd81: s = 8'd127; 8'd82: s = 8'd93; 8'd83: s = 8'd154;
      8'd84: s = 8'd90; 8'd85: s = 8'd144; 8'd86: s = 8'd50; 8'd87: s = 8'd39;
      8'd88: s = 8'd53; 8'd89: s = 8'd62; 8'd90: s = 8'd204; 8'd91: s = 8'd231;
      8'd92: s = 8'd191; 8'd93: s = 8'd247; 8'd94: s = 8'd151; 8'd95: s = 8'd3;
      8'd96: s = 8'd255; 8'd97: s = 8'd25; 8'd98: s = 8'd48; 8'd99: s = 8'd179;
      8'd100: s = 8'd72; 8'd101: s = 8'd165; 8'd102: s = 8'd181; 8'd103: s = 8'd209;
      8'd104: s = 8'd215; 8'd105: s = 8'd94; 8'd106: s = 8'd146; 8'd107: s = 8'd42;
      8'd108: s = 8'd172; 8'd109: s = 8'd86; 8'd110: s = 8'd170; 8'd111: s = 8'd198;
      8'd112: s = 8'd79; 8'd113: s = 8'd184; 8'd114: s = 8'd56; 8'd115: s = 8'd210;
      8'd116: s = 8'd150; 8'd117: s = 8'd164; 8'd118: s = 8'd125; 8'd119: s = 8'd182;
      8'd120: s = 8'd118; 8'd121: s = 8'd252; 8'd122: s = 8'd107; 8'd123: s = 8'd226;
      8'd124: s = 8'd156; 8'd125: s = 8'd116; 8'd126: s = 8'd4; 8'd127: s = 8'd241;
      8'd128: s = 8'd69; 8'd129: s = 8'd157; 8'd130: s = 8'd112; 8'd131: s = 8'd89;
      8'd132: s = 8'd100; 8'd133: s = 8'd113; 8'd134: s = 8'd135; 8'd135: s = 8'd32;
      8'd136: s = 8'd134; 8'd137: s = 8'd91; 8'd138: s = 8'd207; 8'd139: s = 8'd101;
      8'd140: s = 8'd230; 8'd141: s = 8'd45; 8'd142: s = 8'd168; 8'd143: s = 8'd2;
      8'd144: s = 8'd27; 8'd145: s = 8'd96; 8'd146: s = 8'd37; 8'd147: s = 8'd173;
      8'd148: s = 8'd174; 8'd149: s = 8'd176; 8'd150: s = 8'd185; 8'd151: s = 8'd246;
      8'd152: s = 8'd28; 8'd153: s = 8'd70; 8'd154: s = 8'd97; 8'd155: s = 8'd105;
      8'd156: s = 8'd52; 8'd157: s = 8'd64; 8'd158: s = 8'd126; 8'd159: s = 8'd15;
      8'd160: s = 8'd85; 8'd161: s = 8'd71; 8'd162: s = 8'd163; 8'd163: s = 8'd35;
      8'd164: s = 8'd221; 8'd165: s = 8'd81; 8'd166: s = 8'd175; 8'd167: s = 8'd58;
      8'd168: s = 8'd195; 8'd169: s = 8'd92; 8'd170: s = 8'd249; 8'd171: s = 8'd206;
      8'd172: s = 8'd186; 8'd173: s = 8'd197; 8'd174: s = 8'd234; 8'd175: s = 8'd38;
      8'd176: s = 8'd44; 8'd177: s = 8'd83; 8'd178: s = 8'd13; 8'd179: s = 8'd110;
      8'd180: s = 8'd133; 8'd181: s = 8'd40; 8'd182: s = 8'd132; 8'd183: s = 8'd9;
      8'd184: s = 8'd211; 8'd185: s = 8'd223; 8'd186: s = 8'd205; 8'd187: s = 8'd244;
      8'd188: s = 8'd65; 8'd189: s = 8'd129; 8'd190: s = 8'd77; 8'd191: s = 8'd82;
      8'd192: s = 8'd106; 8'd193: s = 8'd220; 8'd194: s = 8'd55; 8'd195: s = 8'd200;
      8'd196: s = 8'd108; 8'd197: s = 8'd193; 8'd198: s = 8'd171; 8'd199: s = 8'd250;
      8'd200: s = 8'd36; 8'd201: s = 8'd225; 8'd202: s = 8'd123; 8'd203: s = 8'd8;
      8'd204: s = 8'd12; 8'd205: s = 8'd189; 8'd206: s = 8'd177; 8'd207: s = 8'd74;
      8'd208: s = 8'd120; 8'd209: s = 8'd136; 8'd210: s = 8'd149; 8'd211: s = 8'd139;
      8'd212: s = 8'd227; 8'd213: s = 8'd99; 8'd214: s = 8'd232; 8'd215: s = 8'd109;
      8'd216: s = 8'd233; 8'd217: s = 8'd203; 8'd218: s = 8'd213; 8'd219: s = 8'd254;
      8'd220: s = 8'd59; 8'd221: s = 8'd0; 8'd222: s = 8'd29; 8'd223: s = 8'd57;
      8'd224: s = 8'd242; 8'd225: s = 8'd239; 8'd226: s = 8'd183; 8'd227: s = 8'd14;
      8'd228: s = 8'd102; 8'd229: s = 8'd88; 8'd230: s = 8'd208; 8'd231: s = 8'd228;
      8'd232: s = 8'd166; 8'd233: s = 8'd119; 8'd234: s = 8'd114; 8'd235: s = 8'd248;
      8'd236: s = 8'd235; 8'd237: s = 8'd117; 8'd238: s = 8'd75; 8'd239: s = 8'd10;
      8'd240: s = 8'd49; 8'd241: s = 8'd68; 8'd242: s = 8'd80; 8'd243: s = 8'd180;
      8'd244: s = 8'd143; 8'd245: s = 8'd237; 8'd246: s = 8'd31; 8'd247: s = 8'd26;
      8'd248: s = 8'd219; 8'd249: s = 8'd153; 8'd250: s = 8'd141; 8'd251: s = 8'd51;
      8'd252: s = 8'd159; 8'd253: s = 8'd17; 8'd254: s = 8'd131; 8'd255: s = 8'd20;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* rtl/md2_ram.sv */
// ----------------------------------------------------------------------------
// md2_ram
// Single-write, single-read synchronous RAM holding all MD2 working state.
// ----------------------------------------------------------------------------
`default_nettype none
module md2_ram
  import md2_pkg::*;
(
  input  wire logic         clk,
  input  wire md2_mem_cmd_t cmd,
  output logic [7:0]        rdata
);

  // Map: 0..47 hash state, 48..63 checksum. Reset is done by a clearing pass.
  logic [7:0] mem [64];

  // Registered read, write port beside it.
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    rdata <= mem[cmd.raddr];
  end

endmodule
`default_nettype wire

/* rtl/md2_hash_engine.sv */
// ----------------------------------------------------------------------------
// md2_hash_engine
// MD2 digest engine: byte absorb, block compression and digest output.
// ----------------------------------------------------------------------------
// An absorb beat that fills the 16-byte buffer starts a block. The single read
// port of the state RAM sets its pace: each checksum byte steps through S_CKRD,
// S_CKWR, S_CKW2 and S_LSTW, and each of the 18 rounds does a read in S_RND
// and a write in S_RNDW per byte along the chained 48-byte round. A finish beat
// runs two such blocks, the padded tail and then the checksum, with a checksum
// copy between them. A digest read and a clearing pass follow, and the digest
// beat is offered after the S_OUT state. No new beat is taken while a digest
// beat waits. After reset a clearing pass over all 64 RAM bytes runs before the
// first beat is accepted. The block buffer and fill count are flip-flops.
`default_nettype none
module md2_hash_engine
  import md2_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] data_byte
  input  wire logic         in_tuser,   // [0] op
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata   // [63:0] digest_high, [127:64] digest_low
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CKRD = 4'd2;   // read hash byte X[k]
  localparam logic [3:0] S_CKWR = 4'd3;   // latch X[k], read checksum byte k, write X[16+k]
  localparam logic [3:0] S_CKW2 = 4'd4;   // write X[32+k]
  localparam logic [3:0] S_RND  = 4'd5;   // read X[k]
  localparam logic [3:0] S_RNDW = 4'd6;   // write X[k]
  localparam logic [3:0] S_DIG  = 4'd7;   // read digest bytes
  localparam logic [3:0] S_OUT  = 4'd8;
  localparam logic [3:0] S_LAST = 4'd9;   // load checksum as last block
  localparam logic [3:0] S_LSTW = 4'd10;

  logic [3:0]   state_r, state_nxt;
  logic [6:0]   cnt_r, cnt_nxt;       // byte index / clear index
  logic [4:0]   rnd_r, rnd_nxt;
  logic [7:0]   t_r, t_nxt;           // chaining byte
  logic [7:0]   x_r, x_nxt;           // held X[k] during checksum step
  logic [1:0]   phase_r, phase_nxt;   // 0 absorb, 1 finish first, 2 finish last
  logic [3:0]   fill_r, fill_nxt;
  logic [7:0]   buf_r [16];
  logic [7:0]   buf_nxt [16];
  logic [127:0] dig_r, dig_nxt;
  logic         ovld_r, ovld_nxt;
  logic         dig_go_r, dig_go_nxt;
  md2_mem_cmd_t cmd;
  logic [7:0]   rdata;

  md2_ram u_ram (.clk(clk), .cmd(cmd), .rdata(rdata));

  assign in_tready  = (state_r == S_IDLE) && !ovld_r;
  assign out_tvalid = ovld_r;
  assign out_tdata  = dig_r;

  // Sequencer over the state RAM.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rnd_nxt    = rnd_r;
    t_nxt      = t_r;
    x_nxt      = x_r;
    phase_nxt  = phase_r;
    fill_nxt   = fill_r;
    buf_nxt    = buf_r;
    dig_nxt    = dig_r;
    ovld_nxt   = ovld_r;
    dig_go_nxt = dig_go_r;
    cmd        = '0;
    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end
    case (state_r)
      S_CLR: begin
        cmd.we    = 1'b1;
        cmd.waddr = cnt_r[5:0];
        cmd.wdata = 8'd0;
        cnt_nxt   = cnt_r + 7'd1;
        fill_nxt  = 4'd0;
        for (int i = 0; i < 16; i++) buf_nxt[i] = 8'd0;
        if (cnt_r == 7'd63) begin
          cnt_nxt  = '0;
          state_nxt = dig_go_r ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_tuser == OP_ABSORB) begin
            buf_nxt[fill_r] = in_tdata;
            fill_nxt = fill_r + 4'd1;
            if (fill_r == 4'd15) begin
              phase_nxt = 2'd0;
              cnt_nxt   = '0;
              state_nxt = S_CKRD;
            end
          end else begin
            for (int i = 0; i < 16; i++) begin
              if (4'(i) >= fill_r) buf_nxt[i] = 8'd16 - {4'd0, fill_r};
            end
            fill_nxt  = 4'd0;
            phase_nxt = 2'd1;
            cnt_nxt   = '0;
            state_nxt = S_CKRD;
          end
        end
      end
      S_CKRD: begin
        // Read X[k] first; checksum byte k follows.
        cmd.raddr = cnt_r[5:0];
        state_nxt = S_CKWR;
      end
      S_CKWR: begin
        x_nxt     = rdata;
        cmd.raddr = 6'd48 + {2'd0, cnt_r[3:0]};
        cmd.we    = 1'b1;
        cmd.waddr = 6'd16 + {2'd0, cnt_r[3:0]};
        cmd.wdata = buf_r[cnt_r[3:0]];
        state_nxt = S_CKW2;
      end
      S_CKW2: begin
        cmd.we    = 1'b1;
        cmd.waddr = 6'd32 + {2'd0, cnt_r[3:0]};
        cmd.wdata = buf_r[cnt_r[3:0]] ^ x_r;
        // The checksum write needs the port too; it goes next cycle via S_LSTW.
        t_nxt     = rdata ^ md2_sbox(buf_r[cnt_r[3:0]] ^ t_r);
        state_nxt = S_LSTW;
      end
      S_LSTW: begin
        cmd.we    = 1'b1;
        cmd.waddr = 6'd48 + {2'd0, cnt_r[3:0]};
        cmd.wdata = t_r;
        if (cnt_r[3:0] == 4'd15) begin
          cnt_nxt   = '0;
          rnd_nxt   = '0;
          t_nxt     = 8'd0;
          state_nxt = S_RND;
        end else begin
          cnt_nxt   = cnt_r + 7'd1;
          state_nxt = S_CKRD;
        end
      end
      S_RND: begin
        cmd.raddr = cnt_r[5:0];
        state_nxt = S_RNDW;
      end
      S_RNDW: begin
        cmd.we    = 1'b1;
        cmd.waddr = cnt_r[5:0];
        cmd.wdata = rdata ^ md2_sbox(t_r);
        t_nxt     = rdata ^ md2_sbox(t_r);
        state_nxt = S_RND;
        if (cnt_r == 7'd47) begin
          cnt_nxt = '0;
          t_nxt   = (rdata ^ md2_sbox(t_r)) + {3'd0, rnd_r};
          if (rnd_r == 5'd17) begin
            case (phase_r)
              2'd0: state_nxt = S_IDLE;
              2'd1: state_nxt = S_LAST;
              default: state_nxt = S_DIG;
            endcase
          end else begin
            rnd_nxt = rnd_r + 5'd1;
          end
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      S_LAST: begin
        // Copy the checksum into the block buffer, one byte per cycle.
        cmd.raddr = 6'd48 + {2'd0, cnt_r[3:0]};
        if (cnt_r != 7'd0) buf_nxt[cnt_r[3:0] - 4'd1] = rdata;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd16) begin
          buf_nxt[15] = rdata;
          cnt_nxt   = '0;
          phase_nxt = 2'd2;
          state_nxt = S_CKRD;
        end
      end
      S_DIG: begin
        cmd.raddr = cnt_r[5:0];
        if (cnt_r != 7'd0) begin
          if (cnt_r <= 7'd8) dig_nxt[64 - 8*cnt_r[3:0] +: 8] = rdata;
          else dig_nxt[128 - 8*(cnt_r[4:0] - 5'd8) +: 8] = rdata;
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd16) begin
          cnt_nxt    = '0;
          dig_go_nxt = 1'b1;
          state_nxt  = S_CLR;
        end
      end
      S_OUT: begin
        ovld_nxt   = 1'b1;
        dig_go_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // t must start each block as checksum[15]: a copy is kept in ck15_r after
  // each write of checksum[15], and cleared by reset/clear.
  logic [7:0] ck15_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      cnt_r    <= '0;
      fill_r   <= '0;
      ovld_r   <= 1'b0;
      dig_go_r <= 1'b0;
      phase_r  <= '0;
      ck15_r   <= '0;
      t_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      fill_r   <= fill_nxt;
      ovld_r   <= ovld_nxt;
      dig_go_r <= dig_go_nxt;
      phase_r  <= phase_nxt;
      if (state_r == S_CLR) ck15_r <= 8'd0;
      else if (state_r == S_LSTW && cnt_r[3:0] == 4'd15) ck15_r <= t_r;
      if ((state_r == S_IDLE && state_nxt == S_CKRD) ||
          (state_r == S_LAST && state_nxt == S_CKRD)) begin
        t_r <= ck15_r;
      end else begin
        t_r <= t_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    rnd_r <= rnd_nxt;
    x_r   <= x_nxt;
    buf_r <= buf_nxt;
    dig_r <= dig_nxt;
  end

`ifndef SYNTHESIS
  // No new beat while a digest is waiting.
  a_no_in_with_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken with digest pending");
  // A digest only appears after the clearing pass.
  a_out_after_clr: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovld_r) |-> $past(state_r) == S_OUT) else $error("digest out of order");
  // Round counter stays within the 18 rounds.
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RNDW |-> rnd_r < 5'd18) else $error("round count overrun");
`endif

endmodule
`default_nettype wire
